@@ rtl/core/ssa_pkg.sv @@
// ----------------------------------------------------------------------------
// Swap slot allocator package
// Shared types, codes and default sizes of the swap slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

   // Default sizes
   localparam int NUM_SLOTS_DEF         = 128;
   localparam int PAGES_PER_PROCESS_DEF = 32;
   localparam int NUM_PROCESSES_DEF     = 64;

   // Field widths
   localparam int MODE_W   = 2;
   localparam int PID_W    = 6;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 3;
   localparam int BLK_W    = 24;

   // Eight disk blocks per slot
   localparam int SLOT_SHIFT = 3;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_STORE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_REUSED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEW     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FREE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [PID_W-1:0]  process_id;
      logic [ADDR_W-1:0] page_address;
   } ssa_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BLK_W-1:0]    block_number;
   } ssa_rsp_type;

   typedef struct packed {
      logic [BLK_W-1:0] base_block;
   } ssa_csr_type;

   // Result summary from the engine to the output stage
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                has_block;
   } ssa_res_type;

endpackage

@@ rtl/core/ssa_chan_if.sv @@
// ----------------------------------------------------------------------------
// Swap slot allocator channel
// Valid/ready channel carrying one item of the given payload type.
// ----------------------------------------------------------------------------
interface ssa_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/swap_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// Swap slot allocator
// Backing-store slot table: store, free and clear requests, one result each.
//
//   channel  dir  payload                                   accepted when
//   req_if   in   mode, process_id, page_address            valid && ready
//   rsp_if   out  status, block_number                      valid && ready
//   csr_if   in   base_block                                valid (ready tied high)
//
// Store: a list count read, then the list search, then the free slot scan
//   through the slot table read port.
// Free: a list count read, then each listed slot is released and the list emptied.
// Clear: a clearing pass over the slot table.
// After reset a clearing pass over the slot table and the list counts runs
//   before the first item is taken.
// One item at a time; a finished result waits in the output register while
//   the next item is taken, and the engine stalls only if that one is done too.
// ----------------------------------------------------------------------------
module swap_slot_allocator #(
   parameter int NUM_SLOTS         = ssa_pkg::NUM_SLOTS_DEF,
   parameter int PAGES_PER_PROCESS = ssa_pkg::PAGES_PER_PROCESS_DEF,
   parameter int NUM_PROCESSES     = ssa_pkg::NUM_PROCESSES_DEF
) (
   input logic        clock,
   input logic        reset,
   ssa_chan_if.sink   req_if,
   ssa_chan_if.source rsp_if,
   ssa_chan_if.sink   csr_if
);
   import ssa_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);

   logic              done_valid;
   logic              done_ready;
   ssa_res_type       done_info;
   logic [SLOT_W-1:0] done_slot;
   logic [BLK_W-1:0]  block;

   logic [BLK_W-1:0]  base_block_ff;
   logic              rsp_valid_ff;
   ssa_rsp_type       rsp_ff;

   ssa_engine #(
      .NUM_SLOTS         (NUM_SLOTS),
      .PAGES_PER_PROCESS (PAGES_PER_PROCESS),
      .NUM_PROCESSES     (NUM_PROCESSES),
      .SLOT_W            (SLOT_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_item   (req_if.payload),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_info  (done_info),
      .done_slot  (done_slot)
   );

   // Base block register
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_block_ff <= '0;
      end else if (csr_if.valid) begin
         base_block_ff <= csr_if.payload.base_block;
      end
   end

   // First block of the slot, wrapping at 24 bits
   assign block = done_info.has_block
                ? base_block_ff + BLK_W'({done_slot, {SLOT_SHIFT{1'b0}}})
                : '0;

   // Output register
   assign done_ready = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_valid && done_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_valid && done_ready) begin
         rsp_ff.status       <= done_info.status;
         rsp_ff.block_number <= block;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

endmodule

@@ rtl/core/ssa_engine.sv @@
// ----------------------------------------------------------------------------
// Swap slot allocator engine
// Sequencer around the slot, slot list and list count memories.
// ----------------------------------------------------------------------------
module ssa_engine #(
   parameter int NUM_SLOTS         = ssa_pkg::NUM_SLOTS_DEF,
   parameter int PAGES_PER_PROCESS = ssa_pkg::PAGES_PER_PROCESS_DEF,
   parameter int NUM_PROCESSES     = ssa_pkg::NUM_PROCESSES_DEF,
   parameter int SLOT_W            = $clog2(NUM_SLOTS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ssa_pkg::ssa_req_type req_item,
   output logic                done_valid,
   input  logic                done_ready,
   output ssa_pkg::ssa_res_type done_info,
   output logic [SLOT_W-1:0]   done_slot
);
   import ssa_pkg::*;

   localparam int CNT_W      = $clog2(PAGES_PER_PROCESS + 1);
   localparam int IDX_W      = $clog2(PAGES_PER_PROCESS);
   localparam int PROC_W     = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam int LIST_DEPTH = NUM_PROCESSES * PAGES_PER_PROCESS;
   localparam int LIST_AW    = $clog2(LIST_DEPTH);
   localparam int SWEEP_N    = (NUM_SLOTS > NUM_PROCESSES) ? NUM_SLOTS : NUM_PROCESSES;
   localparam int SWP_W      = $clog2(SWEEP_N);
   localparam int ENT_W      = ADDR_W + 1;   // {in_use, owner}

   // Sequencer states
   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_CNT  = 3'd2;
   localparam logic [2:0] S_SRCH = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_FREE = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   // Memories
   logic [ENT_W-1:0]  slot_mem [NUM_SLOTS];
   logic [SLOT_W-1:0] list_mem [LIST_DEPTH];
   logic [CNT_W-1:0]  cnt_mem  [NUM_PROCESSES];

   // Control and working registers
   logic [2:0]          state_ff, state_in;
   logic [SWP_W-1:0]    sweep_ff, sweep_in;
   logic                clr_cnt_ff, clr_cnt_in;
   logic [MODE_W-1:0]   mode_ff;
   logic [PROC_W-1:0]   pid_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [LIST_AW-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]    i_ff, i_in;
   logic [SLOT_W:0]     j_ff, j_in;
   logic                vb_ff, vb_in;
   logic                vc_ff, vc_in;
   logic [SLOT_W-1:0]   s_ff, s_in;
   ssa_res_type         res_ff, res_in;

   // Memory ports
   logic                slot_we, slot_re;
   logic [SLOT_W-1:0]   slot_waddr, slot_raddr;
   logic [ENT_W-1:0]    slot_wdata, slot_q_ff;
   logic                list_we, list_re;
   logic [LIST_AW-1:0]  list_waddr, list_raddr;
   logic [SLOT_W-1:0]   list_wdata, list_q_ff;
   logic                cnt_we, cnt_re;
   logic [PROC_W-1:0]   cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]    cnt_wdata, cnt_q_ff;

   // Request decode
   logic [PROC_W+PID_W-1:0] pid_wide;
   logic [PROC_W-1:0]       pid_idx;
   logic                    pid_ok;
   logic                    accept;
   logic                    issue;
   logic                    match;
   logic                    found;

   assign pid_wide = (PROC_W + PID_W)'(req_item.process_id);
   assign pid_idx  = pid_wide[PROC_W-1:0];
   assign pid_ok   = 32'(req_item.process_id) < 32'(NUM_PROCESSES);
   assign accept   = req_valid && req_ready;

   assign match = vc_ff && slot_q_ff[ADDR_W] && (slot_q_ff[ADDR_W-1:0] == addr_ff);
   assign found = vc_ff && !slot_q_ff[ADDR_W];

   assign done_info = res_ff;
   assign done_slot = s_ff;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      sweep_in   = sweep_ff;
      clr_cnt_in = clr_cnt_ff;
      cnt_in     = cnt_ff;
      base_in    = base_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      vb_in      = 1'b0;
      vc_in      = 1'b0;
      s_in       = s_ff;
      res_in     = res_ff;
      req_ready  = 1'b0;
      done_valid = 1'b0;
      issue      = 1'b0;
      slot_we    = 1'b0;
      slot_waddr = s_ff;
      slot_wdata = '0;
      slot_re    = 1'b0;
      slot_raddr = s_ff;
      list_we    = 1'b0;
      list_waddr = base_ff;
      list_wdata = s_ff;
      list_re    = 1'b0;
      list_raddr = base_ff;
      cnt_we     = 1'b0;
      cnt_waddr  = pid_ff;
      cnt_wdata  = '0;
      cnt_re     = 1'b0;
      cnt_raddr  = pid_idx;

      case (state_ff)
         // Clearing pass: slots always, list counts only after reset
         S_CLR: begin
            if (32'(sweep_ff) < 32'(NUM_SLOTS)) begin
               slot_we    = 1'b1;
               slot_waddr = sweep_ff[SLOT_W-1:0];
            end
            if (clr_cnt_ff && (32'(sweep_ff) < 32'(NUM_PROCESSES))) begin
               cnt_we    = 1'b1;
               cnt_waddr = sweep_ff[PROC_W-1:0];
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWP_W'(SWEEP_N - 1)) begin
               if (clr_cnt_ff) begin
                  state_in = S_IDLE;
               end else begin
                  res_in   = '{status: ST_DONE, has_block: 1'b0};
                  state_in = S_DONE;
               end
            end
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_item.mode)
                  MODE_STORE: begin
                     if (pid_ok) begin
                        cnt_re   = 1'b1;
                        state_in = S_CNT;
                     end else begin
                        res_in   = '{status: ST_FULL, has_block: 1'b0};
                        state_in = S_DONE;
                     end
                  end
                  MODE_FREE: begin
                     if (pid_ok) begin
                        cnt_re   = 1'b1;
                        state_in = S_CNT;
                     end else begin
                        res_in   = '{status: ST_DONE, has_block: 1'b0};
                        state_in = S_DONE;
                     end
                  end
                  MODE_CLEAR: begin
                     sweep_in   = '0;
                     clr_cnt_in = 1'b0;
                     state_in   = S_CLR;
                  end
                  default: begin
                     res_in   = '{status: ST_DONE, has_block: 1'b0};
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // List count arrives; locate the list
         S_CNT: begin
            cnt_in   = cnt_q_ff;
            base_in  = LIST_AW'(32'(pid_ff) * 32'(PAGES_PER_PROCESS));
            i_in     = '0;
            j_in     = '0;
            state_in = (mode_ff == MODE_STORE) ? S_SRCH : S_FREE;
         end

         // Search the list: list read, slot read, owner compare
         S_SRCH: begin
            if (match) begin
               res_in   = '{status: ST_REUSED, has_block: 1'b1};
               state_in = S_DONE;
            end else begin
               issue      = (i_ff != cnt_ff);
               list_re    = issue;
               list_raddr = base_ff + LIST_AW'(i_ff[IDX_W-1:0]);
               i_in       = i_ff + CNT_W'(issue);
               vb_in      = issue;
               slot_re    = vb_ff;
               slot_raddr = list_q_ff;
               vc_in      = vb_ff;
               if (vb_ff) begin
                  s_in = list_q_ff;
               end
               if (!issue && !vb_ff && !vc_ff) begin
                  if (cnt_ff >= CNT_W'(PAGES_PER_PROCESS)) begin
                     res_in   = '{status: ST_FULL, has_block: 1'b0};
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end

         // Scan the slot table for the lowest free slot
         S_SCAN: begin
            if (found) begin
               slot_we    = 1'b1;
               slot_waddr = s_ff;
               slot_wdata = {1'b1, addr_ff};
               list_we    = 1'b1;
               list_waddr = base_ff + LIST_AW'(cnt_ff[IDX_W-1:0]);
               list_wdata = s_ff;
               cnt_we     = 1'b1;
               cnt_waddr  = pid_ff;
               cnt_wdata  = cnt_ff + 1'b1;
               res_in     = '{status: ST_NEW, has_block: 1'b1};
               state_in   = S_DONE;
            end else begin
               issue      = (j_ff != (SLOT_W + 1)'(NUM_SLOTS));
               slot_re    = issue;
               slot_raddr = j_ff[SLOT_W-1:0];
               if (issue) begin
                  s_in = j_ff[SLOT_W-1:0];
               end
               vc_in = issue;
               j_in  = j_ff + (SLOT_W + 1)'(issue);
               if (!issue && !vc_ff) begin
                  res_in   = '{status: ST_NO_FREE, has_block: 1'b0};
                  state_in = S_DONE;
               end
            end
         end

         // Release every slot the list names, then empty the list
         S_FREE: begin
            issue      = (i_ff != cnt_ff);
            list_re    = issue;
            list_raddr = base_ff + LIST_AW'(i_ff[IDX_W-1:0]);
            i_in       = i_ff + CNT_W'(issue);
            vb_in      = issue;
            if (vb_ff) begin
               slot_we    = 1'b1;
               slot_waddr = list_q_ff;
            end
            if (!issue && !vb_ff) begin
               cnt_we    = 1'b1;
               cnt_waddr = pid_ff;
               res_in    = '{status: ST_DONE, has_block: 1'b0};
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         sweep_ff   <= '0;
         clr_cnt_ff <= 1'b1;
         vb_ff      <= 1'b0;
         vc_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         clr_cnt_ff <= clr_cnt_in;
         vb_ff      <= vb_in;
         vc_ff      <= vc_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_item.mode;
         pid_ff  <= pid_idx;
         addr_ff <= req_item.page_address;
      end
      cnt_ff  <= cnt_in;
      base_ff <= base_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      s_ff    <= s_in;
      res_ff  <= res_in;
   end

   // Slot table: {in_use, owner}
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_q_ff <= slot_mem[slot_raddr];
      end
   end

   // Per-process slot lists
   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_waddr] <= list_wdata;
      end
      if (list_re) begin
         list_q_ff <= list_mem[list_raddr];
      end
   end

   // Per-process list counts
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_q_ff <= cnt_mem[cnt_raddr];
      end
   end

   // Checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH || state_ff == S_SCAN || state_ff == S_FREE)
      |-> (cnt_ff <= CNT_W'(PAGES_PER_PROCESS)))
      else $error("list count above list capacity");

   a_srch_pipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH && vc_ff) |-> $past(vb_ff))
      else $error("owner compare without a list read ahead of it");

   a_claim: assert property (@(posedge clock) disable iff (reset)
      list_we |-> (slot_we && cnt_we && slot_wdata[ADDR_W]))
      else $error("slot claim without table and count update");

   a_free_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE && slot_we) |-> !slot_wdata[ADDR_W])
      else $error("free request marked a slot in use");

endmodule
